@@ sv/srt_pkg.sv @@
// Package: sorted range table types, constants and codes.
package srt_pkg;

  localparam int unsigned Entries  = 64;
  localparam int unsigned KeyBits  = 64;
  localparam int unsigned IdxW     = $clog2(Entries);
  localparam int unsigned CntW     = $clog2(Entries + 1);
  localparam int unsigned SeqW     = 7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_UPDATED  = 3'd2,
    ST_ABSENT   = 3'd3,
    ST_HIT      = 3'd4,
    ST_MISS     = 3'd5,
    ST_FULL     = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DECIDE,
    S_FETCH_RD,
    S_FETCH_DONE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] entry_key;
    logic [31:0] name_id;
    logic [31:0] payload;
  } srt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] found_key;
    logic [31:0] found_name;
    logic [31:0] found_payload;
    logic [6:0]  seq_number;
  } srt_out_t;

  typedef struct packed {
    logic [KeyBits-1:0] key;
    logic [31:0]        name;
    logic [31:0]        payload;
    logic [SeqW-1:0]    seq;
  } entry_t;

  typedef struct packed {
    logic         we;
    logic [IdxW-1:0] waddr;
    entry_t       wdata;
    logic [IdxW-1:0] raddr;
  } mem_req_t;

endpackage

@@ sv/srt_ram.sv @@
// Module: entry memory, one write and one registered read per cycle.
module srt_ram
  import srt_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output entry_t   rdata_o
);

  entry_t mem [Entries];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule

@@ sv/sorted_range_table_top.sv @@
// Top level: sorted range table with insert, update-by-name and ceiling lookup.
// One transaction is handled at a time in an entry memory with a registered
// read. Each binary search step is a read state and a compare state, with up to
// 7 steps for 64 entries. A lookup hit then reads its entry in the fetch states,
// while a miss goes straight to output. Insert moves each entry up with a read
// state and a write state, then places the new entry; update-by-name reads and
// compares each entry scanned. The result is held in an output register; the
// next transaction is taken in the idle state after it has been delivered.
module sorted_range_table_top
  import srt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  srt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output srt_out_t out_data_o
);

  state_e state_q, state_d;
  srt_in_t req_q, req_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d, ptr_q, ptr_d;
  logic exact_q, exact_d;
  srt_out_t res_q, res_d;
  mem_req_t mreq;
  entry_t rdata;
  logic [CntW-1:0] mid;
  logic [KeyBits-1:0] skey;

  srt_ram u_ram (.clk_i(clk_i), .req_i(mreq), .rdata_o(rdata));

  assign skey = req_q.entry_key[KeyBits-1:0];
  assign mid = lo_q + ((hi_q - lo_q) >> 1);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    ptr_q   <= ptr_d;
    exact_q <= exact_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (cmd_e'(in_data_i.cmd))
            CMD_INSERT, CMD_LOOKUP: state_d = S_SRCH_RD;
            CMD_UPDATE: state_d = S_SCAN_RD;
            default: state_d = S_OUT;
          endcase
        end
      end
      S_SRCH_RD:  state_d = (lo_q < hi_q) ? S_SRCH_CMP : S_DECIDE;
      S_SRCH_CMP: state_d = (skey == rdata.key) ? S_DECIDE : S_SRCH_RD;
      S_DECIDE: begin
        if (req_q.cmd == CMD_LOOKUP) begin
          state_d = (lo_q < count_q) ? S_FETCH_RD : S_OUT;
        end else if (exact_q) begin
          state_d = S_FETCH_RD;
        end else if (count_q >= CntW'(Entries)) begin
          state_d = S_OUT;
        end else begin
          state_d = (ptr_q > lo_q) ? S_SHIFT_RD : S_PLACE;
        end
      end
      S_FETCH_RD:   state_d = S_FETCH_DONE;
      S_FETCH_DONE: state_d = S_OUT;
      S_SHIFT_RD:   state_d = S_SHIFT_WR;
      S_SHIFT_WR:   state_d = (ptr_q - 1'b1 > lo_q) ? S_SHIFT_RD : S_PLACE;
      S_PLACE:      state_d = S_OUT;
      S_SCAN_RD:    state_d = (ptr_q < count_q) ? S_SCAN_CMP : S_OUT;
      S_SCAN_CMP:   state_d = (rdata.name == req_q.name_id) ? S_OUT : S_SCAN_RD;
      S_OUT:        state_d = out_stall_i ? S_OUT : S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_d   = req_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    ptr_d   = ptr_q;
    exact_d = exact_q;
    res_d   = res_q;
    count_d = count_q;
    mreq.we    = 1'b0;
    mreq.waddr = ptr_q[IdxW-1:0];
    mreq.wdata = rdata;
    mreq.raddr = mid[IdxW-1:0];
    case (state_q)
      S_IDLE: begin
        req_d   = in_data_i;
        lo_d    = '0;
        hi_d    = count_q;
        ptr_d   = '0;
        exact_d = 1'b0;
        res_d   = '0;
        res_d.status = ST_MISS;
      end
      S_SRCH_RD: begin
        ptr_d = count_q;
      end
      S_SRCH_CMP: begin
        if (skey == rdata.key) begin
          exact_d = 1'b1;
          lo_d = mid;
        end else if (skey < rdata.key) begin
          hi_d = mid;
        end else begin
          lo_d = mid + 1'b1;
        end
      end
      S_DECIDE: begin
        ptr_d = count_q;
        if (req_q.cmd == CMD_INSERT && !exact_q && count_q >= CntW'(Entries)) begin
          res_d.status = ST_FULL;
        end
      end
      S_FETCH_RD: begin
        mreq.raddr = lo_q[IdxW-1:0];
      end
      S_FETCH_DONE: begin
        res_d.seq_number = rdata.seq;
        if (req_q.cmd == CMD_LOOKUP) begin
          res_d.status        = ST_HIT;
          res_d.found_key     = 64'(rdata.key);
          res_d.found_name    = rdata.name;
          res_d.found_payload = rdata.payload;
        end else begin
          res_d.status = ST_PRESENT;
        end
      end
      S_SHIFT_RD: begin
        mreq.raddr = IdxW'(ptr_q - 1'b1);
      end
      S_SHIFT_WR: begin
        mreq.we    = 1'b1;
        mreq.waddr = ptr_q[IdxW-1:0];
        mreq.wdata = rdata;
        ptr_d      = ptr_q - 1'b1;
      end
      S_PLACE: begin
        mreq.we            = 1'b1;
        mreq.waddr         = lo_q[IdxW-1:0];
        mreq.wdata.key     = skey;
        mreq.wdata.name    = req_q.name_id;
        mreq.wdata.payload = req_q.payload;
        mreq.wdata.seq     = SeqW'(count_q + 1'b1);
        count_d            = count_q + 1'b1;
        res_d.status       = ST_INSERTED;
        res_d.seq_number   = SeqW'(count_q + 1'b1);
      end
      S_SCAN_RD: begin
        mreq.raddr = ptr_q[IdxW-1:0];
        res_d.status = ST_ABSENT;
      end
      S_SCAN_CMP: begin
        if (rdata.name == req_q.name_id) begin
          mreq.we          = 1'b1;
          mreq.waddr       = ptr_q[IdxW-1:0];
          mreq.wdata.key   = skey;
          res_d.status     = ST_UPDATED;
          res_d.seq_number = rdata.seq;
        end
        ptr_d = ptr_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/srt_checker.sv @@
// Checker: port-level properties of the sorted range table, bound to the top level.
module srt_checker
  import srt_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input srt_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input srt_out_t out_data_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction accepted at once");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= ST_FULL)
    else $error("bad status");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_HIT |-> out_data_o.found_key == '0)
    else $error("found key set without hit");

endmodule

bind sorted_range_table_top srt_checker u_srt_checker (.*);
